@@ design/mrs_pkg.sv @@
// Shared types, codes and the CRC-16 bit step for the Modbus RTU slave responder.
// No dependencies; used by modbus_rtu_slave_responder through scoped names.
package mrs_pkg;

    // Request channel item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [3:0]  reg_index;
        logic [15:0] reg_value;
    } t_in_item;

    // Response channel item
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic [2:0] coil_state;
    } t_out_item;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DECODE,
        S_FETCH,
        S_LOAD,
        S_CRC,
        S_TAIL_LO,
        S_TAIL_HI
    } t_state;

    // Kind of response frame
    typedef enum logic [1:0] {
        RESP_READ,
        RESP_ECHO,
        RESP_EXC
    } t_resp;

    // Request item types
    localparam logic [1:0] REQ_BYTE       = 2'd0;
    localparam logic [1:0] REQ_REG_UPDATE = 2'd1;
    localparam logic [1:0] REQ_RESTART    = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 1'b1;
    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
    localparam logic [4:0] REG_COUNT_RST  = 5'd11;

    // Function and exception codes
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0] FUNC_WRITE_COIL = 8'h05;
    localparam logic [7:0] EXC_FLAG        = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_DATA = 8'h03;
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Request frame length and index of its last byte
    localparam int unsigned REQ_LEN = 8;
    localparam logic [2:0] REQ_LAST = 3'd7;
    localparam logic [2:0] CHECK_LAST = 3'd5;

    // One bit step of the reflected CRC
    function automatic logic [15:0] crc_step(input logic [15:0] crc);
        logic [15:0] shifted;
        shifted = {1'b0, crc[15:1]};
        return crc[0] ? (shifted ^ CRC_POLY) : shifted;
    endfunction

endpackage

@@ design/mrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/modbus_rtu_slave_responder.sv @@
// Modbus RTU slave responder: request framing, CRC check, register read and coil write.
// Depends on mrs_pkg (types, codes, CRC step) and mrs_ram (input register store).
//
//  Channel   Direction  Handshake                     Payload
//  -------   ---------  ----------------------------  ----------------------------
//  in        input      i_in_valid / o_in_ready       i_in_item  (mrs_pkg::t_in_item)
//  out       output     o_out_valid / i_out_ready     o_out_item (mrs_pkg::t_out_item)
//  cfg       input      i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// The eighth request byte starts the one-bit-per-cycle CRC unit over the six checked
// bytes, then a decode step. Each response body byte then passes through store fetch,
// load and eight CRC steps; the two CRC bytes follow from the tail states.
// Reset is synchronous; the register store needs no clearing pass, as a valid bit
// per entry makes unwritten entries read as zero. A stalled output holds the
// sequencer in its load or tail state; the input side is not ready from the eighth
// byte until the last response byte is loaded or the frame is dropped.
module modbus_rtu_slave_responder #(
    parameter int REG_DEPTH = 16,
    parameter int NUM_COILS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mrs_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mrs_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);

    localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
    localparam int VD = 1 << AW;
    localparam int CW = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;

    // Control state
    mrs_pkg::t_state     r_state, n_state;
    logic [7:0]          r_slave_addr;
    logic [4:0]          r_reg_count;
    logic [2:0]          r_pos, n_pos;
    logic [VD-1:0]       r_reg_valid, n_reg_valid;
    logic [NUM_COILS-1:0] r_coil, n_coil;
    logic                r_out_valid, n_out_valid;

    // Payload and sequencing registers
    logic [7:0]          r_req [mrs_pkg::REQ_LEN];
    logic [15:0]         r_crc, n_crc;
    logic [2:0]          r_bit, n_bit;
    logic [2:0]          r_idx, n_idx;
    mrs_pkg::t_resp      r_kind, n_kind;
    logic [7:0]          r_exc_code, n_exc_code;
    logic [7:0]          r_body_len, n_body_len;
    logic [7:0]          r_k, n_k;
    logic [AW-1:0]       r_reg_ptr, n_reg_ptr;
    logic                r_low_half, n_low_half;
    logic                r_rd_valid;
    logic [7:0]          r_cur_byte, n_cur_byte;
    mrs_pkg::t_out_item  r_out, n_out;

    // Handshake and control decode
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_out_load;
    logic                w_frame_done;
    logic                w_reg_we;
    logic                w_crc_run;

    // Frame decode
    logic [7:0]          w_func;
    logic [15:0]         w_hi, w_lo;
    logic [16:0]         w_sum, w_bound;
    logic                w_crc_ok;
    mrs_pkg::t_resp      w_kind;
    logic [7:0]          w_code;
    logic                w_coil_we, w_coil_val;

    // Datapath
    logic [7:0]          w_crc_byte;
    logic [15:0]         w_crc_next;
    logic [15:0]         w_ram_q, w_rd_data;
    logic [7:0]          w_body_byte;
    logic [7:0]          w_out_byte;
    logic                w_out_last;
    logic [2:0]          w_coil3;

    // Register store
    mrs_ram #(
        .WIDTH (16),
        .DEPTH (REG_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_reg_we),
        .i_waddr (AW'(i_in_item.reg_index)),
        .i_wdata (i_in_item.reg_value),
        .i_raddr (r_reg_ptr),
        .o_rdata (w_ram_q)
    );

    // Coils beyond the configured count show as zero
    for (genvar g = 0; g < 3; g++) begin : g_coil_view
        if (g < NUM_COILS) begin : g_real
            assign w_coil3[g] = r_coil[g];
        end else begin : g_pad
            assign w_coil3[g] = 1'b0;
        end
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_ready   = (r_state == mrs_pkg::S_IDLE);
        w_in_acc     = i_in_valid && o_in_ready;
        w_out_free   = !r_out_valid || i_out_ready;
        w_out_load   = w_out_free && ((r_state == mrs_pkg::S_LOAD) ||
                                      (r_state == mrs_pkg::S_TAIL_LO) ||
                                      (r_state == mrs_pkg::S_TAIL_HI));
        w_frame_done = w_in_acc && (i_in_item.req_type == mrs_pkg::REQ_BYTE) &&
                       (r_pos == mrs_pkg::REQ_LAST);
        w_reg_we     = w_in_acc && (i_in_item.req_type == mrs_pkg::REQ_REG_UPDATE) &&
                       (32'(i_in_item.reg_index) < REG_DEPTH);
        w_crc_run    = (r_state == mrs_pkg::S_CHECK) || (r_state == mrs_pkg::S_CRC);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrs_pkg::S_IDLE: begin
                if (w_frame_done) begin
                    n_state = mrs_pkg::S_CHECK;
                end
            end
            mrs_pkg::S_CHECK: begin
                if (r_bit == 3'd7 && r_idx == mrs_pkg::CHECK_LAST) begin
                    n_state = mrs_pkg::S_DECODE;
                end
            end
            mrs_pkg::S_DECODE: begin
                n_state = w_crc_ok ? mrs_pkg::S_FETCH : mrs_pkg::S_IDLE;
            end
            mrs_pkg::S_FETCH: begin
                n_state = mrs_pkg::S_LOAD;
            end
            mrs_pkg::S_LOAD: begin
                if (w_out_free) begin
                    n_state = mrs_pkg::S_CRC;
                end
            end
            mrs_pkg::S_CRC: begin
                if (r_bit == 3'd7) begin
                    n_state = (r_k == r_body_len - 8'd1) ? mrs_pkg::S_TAIL_LO
                                                         : mrs_pkg::S_FETCH;
                end
            end
            mrs_pkg::S_TAIL_LO: begin
                if (w_out_free) begin
                    n_state = mrs_pkg::S_TAIL_HI;
                end
            end
            mrs_pkg::S_TAIL_HI: begin
                if (w_out_free) begin
                    n_state = mrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrs_pkg::S_IDLE;
            end
        endcase
    end

    // Frame decode: bound check, coil write and response kind
    always_comb begin
        w_func     = r_req[1];
        w_hi       = {r_req[2], r_req[3]};
        w_lo       = {r_req[4], r_req[5]};
        w_sum      = {1'b0, w_hi} + {1'b0, w_lo};
        // clamp the bound to the store depth
        w_bound    = (17'(r_reg_count) > 17'(REG_DEPTH)) ? 17'(REG_DEPTH)
                                                         : 17'(r_reg_count);
        w_crc_ok   = (r_crc == {r_req[7], r_req[6]});
        w_kind     = mrs_pkg::RESP_EXC;
        w_code     = mrs_pkg::EXC_ILLEGAL_FUNC;
        w_coil_we  = 1'b0;
        w_coil_val = 1'b0;
        if (w_func == mrs_pkg::FUNC_READ_INPUT) begin
            if (w_sum > w_bound) begin
                w_code = mrs_pkg::EXC_ILLEGAL_ADDR;
            end else begin
                w_kind = mrs_pkg::RESP_READ;
            end
        end else if (w_func == mrs_pkg::FUNC_WRITE_COIL) begin
            if (32'(w_hi) >= NUM_COILS) begin
                w_code = mrs_pkg::EXC_ILLEGAL_ADDR;
            end else if (w_lo == mrs_pkg::COIL_ON) begin
                w_kind     = mrs_pkg::RESP_ECHO;
                w_coil_we  = 1'b1;
                w_coil_val = 1'b1;
            end else if (w_lo == mrs_pkg::COIL_OFF) begin
                w_kind     = mrs_pkg::RESP_ECHO;
                w_coil_we  = 1'b1;
            end else begin
                w_code = mrs_pkg::EXC_ILLEGAL_DATA;
            end
        end
    end

    // Shared CRC unit: fold in a byte on its first bit, then one shift step
    always_comb begin
        w_crc_byte = (r_state == mrs_pkg::S_CHECK) ? r_req[r_idx] : r_cur_byte;
        w_crc_next = mrs_pkg::crc_step(r_crc ^ ((r_bit == 3'd0) ? {8'h00, w_crc_byte}
                                                               : 16'h0000));
    end

    // Response body byte at position r_k
    always_comb begin
        w_rd_data   = r_rd_valid ? w_ram_q : 16'h0000;
        w_body_byte = 8'h00;
        if (r_k == 8'd0) begin
            w_body_byte = r_slave_addr;
        end else if (r_k == 8'd1) begin
            w_body_byte = (r_kind == mrs_pkg::RESP_EXC) ? (r_req[1] | mrs_pkg::EXC_FLAG)
                                                        : r_req[1];
        end else begin
            case (r_kind)
                mrs_pkg::RESP_READ: begin
                    if (r_k == 8'd2) begin
                        // byte count: low byte of twice the quantity
                        w_body_byte = {r_req[5][6:0], 1'b0};
                    end else begin
                        w_body_byte = r_low_half ? w_rd_data[7:0] : w_rd_data[15:8];
                    end
                end
                mrs_pkg::RESP_ECHO: begin
                    w_body_byte = r_req[r_k[2:0]];
                end
                mrs_pkg::RESP_EXC: begin
                    w_body_byte = r_exc_code;
                end
                default: begin
                    w_body_byte = 8'h00;
                end
            endcase
        end
    end

    // Byte for the output register
    always_comb begin
        case (r_state)
            mrs_pkg::S_TAIL_LO: begin
                w_out_byte = r_crc[7:0];
                w_out_last = 1'b0;
            end
            mrs_pkg::S_TAIL_HI: begin
                w_out_byte = r_crc[15:8];
                w_out_last = 1'b1;
            end
            default: begin
                w_out_byte = w_body_byte;
                w_out_last = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_pos       = r_pos;
        n_reg_valid = r_reg_valid;
        n_coil      = r_coil;
        n_crc       = r_crc;
        n_bit       = r_bit;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_exc_code  = r_exc_code;
        n_body_len  = r_body_len;
        n_k         = r_k;
        n_reg_ptr   = r_reg_ptr;
        n_low_half  = r_low_half;
        n_cur_byte  = r_cur_byte;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        // accept items: collect bytes, load the store, resynchronise
        if (w_in_acc) begin
            case (i_in_item.req_type)
                mrs_pkg::REQ_BYTE: begin
                    n_pos = r_pos + 3'd1;
                end
                mrs_pkg::REQ_REG_UPDATE: begin
                    if (w_reg_we) begin
                        n_reg_valid[AW'(i_in_item.reg_index)] = 1'b1;
                    end
                end
                mrs_pkg::REQ_RESTART: begin
                    n_pos = 3'd0;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end

        if (w_frame_done) begin
            n_crc = mrs_pkg::CRC_INIT;
            n_bit = 3'd0;
            n_idx = 3'd0;
        end

        // advance the CRC unit one bit
        if (w_crc_run) begin
            n_crc = w_crc_next;
            n_bit = r_bit + 3'd1;
            if (r_bit == 3'd7) begin
                n_idx = r_idx + 3'd1;
                n_k   = r_k + 8'd1;
            end
        end

        // latch the response plan and apply a coil write
        if (r_state == mrs_pkg::S_DECODE) begin
            n_kind     = w_kind;
            n_exc_code = w_code;
            case (w_kind)
                mrs_pkg::RESP_READ: n_body_len = 8'd3 + {w_lo[6:0], 1'b0};
                mrs_pkg::RESP_ECHO: n_body_len = 8'd6;
                default:            n_body_len = 8'd3;
            endcase
            n_k        = 8'd0;
            n_reg_ptr  = AW'(w_hi);
            n_low_half = 1'b0;
            n_crc      = mrs_pkg::CRC_INIT;
            n_bit      = 3'd0;
            if (w_crc_ok && w_coil_we) begin
                n_coil[w_hi[CW-1:0]] = w_coil_val;
            end
        end

        if (w_out_load) begin
            n_out.tx_byte    = w_out_byte;
            n_out.last_byte  = w_out_last;
            n_out.coil_state = w_coil3;
            n_out_valid      = 1'b1;
        end

        // hand the body byte to the CRC unit and step through register halves
        if (w_out_load && r_state == mrs_pkg::S_LOAD) begin
            n_cur_byte = w_body_byte;
            if (r_kind == mrs_pkg::RESP_READ && r_k >= 8'd3) begin
                n_low_half = !r_low_half;
                if (r_low_half) begin
                    n_reg_ptr = r_reg_ptr + AW'(1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mrs_pkg::S_IDLE;
            r_slave_addr <= mrs_pkg::SLAVE_ADDR_RST;
            r_reg_count  <= mrs_pkg::REG_COUNT_RST;
            r_pos        <= 3'd0;
            r_reg_valid  <= '0;
            r_coil       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_reg_valid <= n_reg_valid;
            r_coil      <= n_coil;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrs_pkg::CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                    mrs_pkg::CFG_REG_COUNT:  r_reg_count  <= i_cfg_data[4:0];
                    default: begin
                        r_reg_count <= r_reg_count;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_item.req_type == mrs_pkg::REQ_BYTE) begin
            r_req[r_pos] <= i_in_item.rx_byte;
        end
        r_crc      <= n_crc;
        r_bit      <= n_bit;
        r_idx      <= n_idx;
        r_kind     <= n_kind;
        r_exc_code <= n_exc_code;
        r_body_len <= n_body_len;
        r_k        <= n_k;
        r_reg_ptr  <= n_reg_ptr;
        r_low_half <= n_low_half;
        r_rd_valid <= r_reg_valid[r_reg_ptr];
        r_cur_byte <= n_cur_byte;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The eighth byte of a frame always starts the CRC check
    a_frame_starts_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame_done |=> (r_state == mrs_pkg::S_CHECK))
        else $error("complete frame did not start the CRC check");

    // A new response byte only appears from a load or tail state
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == mrs_pkg::S_LOAD ||
                                $past(r_state) == mrs_pkg::S_TAIL_LO ||
                                $past(r_state) == mrs_pkg::S_TAIL_HI))
        else $error("response byte raised outside emission");

    // Body position stays inside the planned frame body
    a_body_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrs_pkg::S_FETCH || r_state == mrs_pkg::S_LOAD ||
         r_state == mrs_pkg::S_CRC) |-> (r_k < r_body_len))
        else $error("body position beyond frame body");

endmodule

@@ bench/tb_modbus_rtu_slave_responder.sv @@
`timescale 1ns / 1ps
// Self-checking bench for modbus_rtu_slave_responder: directed and random request streams,
// with a transaction-level model of the responder predicting every response byte.
// Depends on mrs_pkg (payload types, codes) and the responder RTL.
module tb_modbus_rtu_slave_responder;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 4;
    localparam int REG_DEPTH   = 16;
    localparam int NUM_COILS   = 3;
    localparam int SETTLE      = 120;   // beyond the CRC check of a dropped frame
    localparam int QUIET_LIMIT = 3000;  // cycles without any transaction
    localparam int MAX_SHOWN   = 10;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Kinds of request sequence the random part draws from
    typedef enum int {
        K_READ,
        K_READ_RANGE,
        K_COIL,
        K_COIL_ADDR,
        K_COIL_VALUE,
        K_OTHER_FUNC,
        K_BAD_CRC,
        K_BROKEN,
        K_SIDE
    } t_req_kind;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    mrs_pkg::t_in_item             in_item   = '0;
    logic                          in_ready;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    mrs_pkg::t_out_item            out_item;
    logic                          cfg_we    = 1'b0;
    logic [mrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = '0;

    // Model state: framing, store, coils and the mirrored registers
    logic [3:0]  frame_pos;
    logic [7:0]  req_bytes  [0:7];
    logic [15:0] input_regs [0:REG_DEPTH-1];
    logic [2:0]  coils;
    logic [7:0]  m_addr;
    logic [4:0]  m_count;
    logic [7:0]  resp_bytes [0:2*REG_DEPTH+4];

    mrs_pkg::t_in_item  req_pending [$];   // request transactions not yet driven
    mrs_pkg::t_out_item resp_expect [$];   // response bytes still owed by the block

    int n_queued    = 0;
    int n_sent      = 0;
    int n_err       = 0;
    int quiet       = 0;
    int in_gap      = 0;
    int out_stall   = 0;
    bit idle_on     = 1'b1;
    bit interleave  = 1'b0;
    bit in_hs       = 1'b0;

    modbus_rtu_slave_responder #(
        .REG_DEPTH (REG_DEPTH),
        .NUM_COILS (NUM_COILS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Response model
    // ------------------------------------------------------------------

    // Fold one byte into the reflected Modbus CRC-16
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ mrs_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic modbus_reset();
        int k;
        m_addr    = mrs_pkg::SLAVE_ADDR_RST;
        m_count   = mrs_pkg::REG_COUNT_RST;
        frame_pos = '0;
        coils     = '0;
        for (k = 0; k < 8; k++) req_bytes[k] = '0;
        for (k = 0; k < REG_DEPTH; k++) input_regs[k] = '0;
    endtask

    // Append the CRC to the body in resp_bytes and queue every byte of the frame
    task automatic emit_response(input int len);
        logic [15:0]        crc;
        mrs_pkg::t_out_item o;
        int                 k;
        crc = mrs_pkg::CRC_INIT;
        for (k = 0; k < len; k++) crc = crc_fold(crc, resp_bytes[k]);
        resp_bytes[len]     = crc[7:0];
        resp_bytes[len + 1] = crc[15:8];
        for (k = 0; k < len + 2; k++) begin
            o.tx_byte    = resp_bytes[k];
            o.last_byte  = (k == len + 1);
            o.coil_state = coils;
            resp_expect.push_back(o);
        end
    endtask

    task automatic emit_exception(input logic [7:0] fc, input logic [7:0] code);
        resp_bytes[0] = m_addr;
        resp_bytes[1] = fc | mrs_pkg::EXC_FLAG;
        resp_bytes[2] = code;
        emit_response(3);
    endtask

    task automatic emit_echo(input logic [7:0] fc);
        int k;
        resp_bytes[0] = m_addr;
        resp_bytes[1] = fc;
        for (k = 2; k < 6; k++) resp_bytes[k] = req_bytes[k];
        emit_response(6);
    endtask

    // A complete eight-byte request: check, decode, answer
    task automatic answer_frame();
        logic [15:0] crc;
        logic [15:0] start;
        logic [15:0] qty;
        logic [7:0]  fc;
        int          limit;
        int          k;
        crc = mrs_pkg::CRC_INIT;
        for (k = 0; k < 6; k++) crc = crc_fold(crc, req_bytes[k]);
        // drop a corrupted request without a word
        if (crc != {req_bytes[7], req_bytes[6]}) return;
        fc    = req_bytes[1];
        start = {req_bytes[2], req_bytes[3]};
        qty   = {req_bytes[4], req_bytes[5]};
        if (fc == mrs_pkg::FUNC_READ_INPUT) begin
            limit = (int'(m_count) > REG_DEPTH) ? REG_DEPTH : int'(m_count);
            if (int'(start) + int'(qty) > limit) begin
                emit_exception(fc, mrs_pkg::EXC_ILLEGAL_ADDR);
            end else begin
                resp_bytes[0] = m_addr;
                resp_bytes[1] = fc;
                resp_bytes[2] = {qty[6:0], 1'b0};
                for (k = 0; k < int'(qty); k++) begin
                    resp_bytes[3 + 2*k] = input_regs[int'(start) + k][15:8];
                    resp_bytes[4 + 2*k] = input_regs[int'(start) + k][7:0];
                end
                emit_response(3 + 2*int'(qty));
            end
        end else if (fc == mrs_pkg::FUNC_WRITE_COIL) begin
            if (int'(start) >= NUM_COILS) begin
                emit_exception(fc, mrs_pkg::EXC_ILLEGAL_ADDR);
            end else if (qty == mrs_pkg::COIL_ON) begin
                coils[start[1:0]] = 1'b1;
                emit_echo(fc);
            end else if (qty == mrs_pkg::COIL_OFF) begin
                coils[start[1:0]] = 1'b0;
                emit_echo(fc);
            end else begin
                // coil left as it was
                emit_exception(fc, mrs_pkg::EXC_ILLEGAL_DATA);
            end
        end else begin
            emit_exception(fc, mrs_pkg::EXC_ILLEGAL_FUNC);
        end
    endtask

    // Advance the model by one accepted request transaction
    task automatic modbus_step(input mrs_pkg::t_in_item it);
        case (it.req_type)
            mrs_pkg::REQ_BYTE: begin
                req_bytes[frame_pos[2:0]] = it.rx_byte;
                frame_pos = frame_pos + 1'b1;
                if (frame_pos >= mrs_pkg::REQ_LEN) begin
                    frame_pos = '0;
                    answer_frame();
                end
            end
            mrs_pkg::REQ_REG_UPDATE: input_regs[it.reg_index] = it.reg_value;
            mrs_pkg::REQ_RESTART:    frame_pos = '0;
            default: ;      // unused type: no effect at all
        endcase
    endtask

    task automatic check_response(input mrs_pkg::t_out_item got);
        mrs_pkg::t_out_item want;
        if (resp_expect.size() == 0) begin
            n_err++;
            if (n_err <= MAX_SHOWN)
                $display("%0t: unexpected response byte %h last %b coils %b",
                         $realtime, got.tx_byte, got.last_byte, got.coil_state);
        end else begin
            want = resp_expect.pop_front();
            if (got.tx_byte !== want.tx_byte || got.last_byte !== want.last_byte ||
                got.coil_state !== want.coil_state) begin
                n_err++;
                if (n_err <= MAX_SHOWN)
                    $display({"%0t: response mismatch: byte %h/%h last %b/%b ",
                              "coils %b/%b (exp/got)"},
                             $realtime, want.tx_byte, got.tx_byte, want.last_byte,
                             got.last_byte, want.coil_state, got.coil_state);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            modbus_reset();
            in_hs = 1'b0;
            quiet = 0;
        end else begin
            in_hs = in_valid && in_ready;
            if (cfg_we) begin
                if (cfg_index == mrs_pkg::CFG_SLAVE_ADDR)
                    m_addr = cfg_data;
                else if (cfg_index == mrs_pkg::CFG_REG_COUNT)
                    m_count = cfg_data[4:0];
            end
            if (in_hs) begin
                modbus_step(in_item);
                n_sent++;
            end
            if (out_valid && out_ready)
                check_response(out_item);
            quiet = (in_hs || (out_valid && out_ready)) ? 0 : quiet + 1;
        end
    end

    // Watchdog: give up once nothing has moved for too long
    always @(negedge clk) begin
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_modbus_rtu_slave_responder: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: present the next pending request transaction at the falling edge.
    // Hold the current one until it is taken; insert bursts of idle cycles.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_hs) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                in_valid <= 1'b0;
            end else if (idle_on && req_pending.size() != 0 &&
                         $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 7);
                in_valid <= 1'b0;
            end else if (req_pending.size() != 0) begin
                in_item  <= req_pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall the response channel in random bursts
    always @(negedge clk) begin
        if (!idle_on) begin
            out_ready <= 1'b1;
        end else if (out_stall > 0) begin
            out_stall = out_stall - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_item(input mrs_pkg::t_in_item it);
        req_pending.push_back(it);
        n_queued++;
    endtask

    // Unused fields carry random bits so that every field bit toggles
    task automatic add_byte(input logic [7:0] b);
        mrs_pkg::t_in_item it;
        it.req_type  = mrs_pkg::REQ_BYTE;
        it.rx_byte   = b;
        it.reg_index = 4'($urandom);
        it.reg_value = 16'($urandom);
        add_item(it);
    endtask

    task automatic add_update(input logic [3:0] idx, input logic [15:0] val);
        mrs_pkg::t_in_item it;
        it.req_type  = mrs_pkg::REQ_REG_UPDATE;
        it.rx_byte   = 8'($urandom);
        it.reg_index = idx;
        it.reg_value = val;
        add_item(it);
    endtask

    task automatic add_other(input logic [1:0] kind);
        mrs_pkg::t_in_item it;
        it.req_type  = kind;
        it.rx_byte   = 8'($urandom);
        it.reg_index = 4'($urandom);
        it.reg_value = 16'($urandom);
        add_item(it);
    endtask

    // Register update or ignored item; safe in the middle of a frame
    task automatic add_side();
        logic [15:0] val;
        case ($urandom_range(0, 3))
            0:       val = 16'h0000;
            1:       val = 16'hFFFF;
            default: val = 16'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0)
            add_other(REQ_UNUSED);
        else
            add_update(4'($urandom), val);
    endtask

    // Eight-byte request with its CRC, optionally corrupted by flip
    task automatic add_frame(input logic [7:0] fc, input logic [15:0] hi,
                             input logic [15:0] lo, input logic [15:0] flip);
        logic [7:0]  f [0:7];
        logic [15:0] crc;
        int          k;
        f[0] = 8'($urandom);   // address byte is never checked
        f[1] = fc;
        f[2] = hi[15:8];
        f[3] = hi[7:0];
        f[4] = lo[15:8];
        f[5] = lo[7:0];
        crc  = mrs_pkg::CRC_INIT;
        for (k = 0; k < 6; k++) crc = crc_fold(crc, f[k]);
        crc  = crc ^ flip;
        f[6] = crc[7:0];
        f[7] = crc[15:8];
        for (k = 0; k < 8; k++) begin
            if (interleave && k > 0 && $urandom_range(0, 15) == 0) add_side();
            add_byte(f[k]);
        end
    endtask

    task automatic add_random_request();
        t_req_kind   kind;
        int          limit;
        int          qty;
        int          start;
        int          r;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [7:0]  fc;
        limit = (int'(m_count) > REG_DEPTH) ? REG_DEPTH : int'(m_count);
        r = $urandom_range(0, 15);
        if (r < 5)       kind = K_READ;
        else if (r < 6)  kind = K_READ_RANGE;
        else if (r < 9)  kind = K_COIL;
        else if (r < 10) kind = K_COIL_ADDR;
        else if (r < 11) kind = K_COIL_VALUE;
        else if (r < 12) kind = K_OTHER_FUNC;
        else if (r < 13) kind = K_BAD_CRC;
        else if (r < 14) kind = K_BROKEN;
        else             kind = K_SIDE;
        case (kind)
            K_READ: begin
                qty   = $urandom_range(0, limit);
                start = $urandom_range(0, limit - qty);
                add_frame(mrs_pkg::FUNC_READ_INPUT, 16'(start), 16'(qty), 16'h0000);
            end
            K_READ_RANGE: begin
                if ($urandom_range(0, 1)) begin
                    hi = 16'($urandom);
                    lo = 16'($urandom);
                end else begin
                    start = $urandom_range(0, limit);
                    hi = 16'(start);
                    lo = 16'(limit - start + int'($urandom_range(1, 3)));
                end
                add_frame(mrs_pkg::FUNC_READ_INPUT, hi, lo, 16'h0000);
            end
            K_COIL: begin
                lo = $urandom_range(0, 1) ? mrs_pkg::COIL_ON : mrs_pkg::COIL_OFF;
                add_frame(mrs_pkg::FUNC_WRITE_COIL, 16'($urandom_range(0, NUM_COILS - 1)),
                          lo, 16'h0000);
            end
            K_COIL_ADDR: begin
                hi = $urandom_range(0, 1) ? 16'(NUM_COILS)
                                          : 16'($urandom_range(NUM_COILS, 16'hFFFF));
                lo = $urandom_range(0, 1) ? mrs_pkg::COIL_ON : 16'($urandom);
                add_frame(mrs_pkg::FUNC_WRITE_COIL, hi, lo, 16'h0000);
            end
            K_COIL_VALUE: begin
                lo = 16'($urandom);
                if (lo == mrs_pkg::COIL_ON || lo == mrs_pkg::COIL_OFF) lo = lo ^ 16'h0100;
                add_frame(mrs_pkg::FUNC_WRITE_COIL, 16'($urandom_range(0, NUM_COILS - 1)),
                          lo, 16'h0000);
            end
            K_OTHER_FUNC: begin
                fc = 8'($urandom);
                if (fc == mrs_pkg::FUNC_READ_INPUT || fc == mrs_pkg::FUNC_WRITE_COIL)
                    fc = fc | mrs_pkg::EXC_FLAG;
                add_frame(fc, 16'($urandom), 16'($urandom), 16'h0000);
            end
            K_BAD_CRC: begin
                case ($urandom_range(0, 2))
                    0:       fc = mrs_pkg::FUNC_READ_INPUT;
                    1:       fc = mrs_pkg::FUNC_WRITE_COIL;
                    default: fc = 8'($urandom);
                endcase
                add_frame(fc, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(1, 16'hFFFF)));
            end
            K_BROKEN: begin
                // partial frame, then resynchronise
                repeat ($urandom_range(1, mrs_pkg::REQ_LEN - 1)) add_byte(8'($urandom));
                add_other(mrs_pkg::REQ_RESTART);
            end
            default: begin
                repeat ($urandom_range(1, 3)) add_side();
            end
        endcase
    endtask

    // Wait until every transaction has gone in and every response byte has come out
    task automatic wait_idle(input int settle);
        while (n_sent != n_queued || resp_expect.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [mrs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Reconfigure once idle, then stream random requests;
    // with pressure set, hold off half way until the responses are all out
    task automatic run_phase(input logic [7:0] addr, input logic [7:0] count,
                             input int n_items, input bit pressure);
        int target;
        wait_idle(SETTLE);
        cfg_write(mrs_pkg::CFG_SLAVE_ADDR, addr);
        cfg_write(mrs_pkg::CFG_REG_COUNT, count);
        target = n_queued + n_items;
        if (pressure) begin
            while (n_queued < target - n_items / 2) add_random_request();
            wait_idle(0);
        end
        while (n_queued < target) add_random_request();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: store extremes, full read at the reset bound, a broken
        // frame healed by a restart, an ignored item, and a coil write.
        add_update(4'd0, 16'hFFFF);
        add_update(4'd15, 16'h0000);
        add_update(4'd10, 16'h8001);
        add_frame(mrs_pkg::FUNC_READ_INPUT, 16'd0, 16'd11, 16'h0000);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(mrs_pkg::FUNC_WRITE_COIL);
        add_other(mrs_pkg::REQ_RESTART);
        add_other(REQ_UNUSED);
        add_frame(mrs_pkg::FUNC_WRITE_COIL, 16'd2, mrs_pkg::COIL_ON, 16'h0000);

        interleave = 1'b1;
        run_phase(8'h00, 8'd0, 60, 1'b0);           // empty bound: only zero-length reads from address zero pass
        run_phase(8'hFF, 8'd16, 70, 1'b1);          // bound at store depth
        run_phase(8'($urandom), 8'd31, 70, 1'b0);   // bound saturated at store depth
        run_phase(8'hA5, 8'hE7, 60, 1'b0);          // upper data bits dropped: bound 7

        // Final stretch at full rate on both channels
        idle_on = 1'b0;
        run_phase(8'($urandom), 8'($urandom_range(0, 16)), 70, 1'b0);

        wait_idle(SETTLE);
        if (n_err == 0)
            $display("tb_modbus_rtu_slave_responder: done, clean");
        else
            $display("tb_modbus_rtu_slave_responder: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mrs_pkg.sv
design/mrs_ram.sv
design/modbus_rtu_slave_responder.sv
bench/tb_modbus_rtu_slave_responder.sv
